// ----- hdl/spq_pkg.sv -----
// shared types and constants of the sorted min priority queue
package spq_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_WIDTH   = $clog2(CAPACITY + 1);
    localparam int PORT_KEY_W  = 32;
    localparam int PORT_CNT_W  = 5;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [IDX_WIDTH-1:0]        count_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
        key_t key;
    } cell_ctrl_t;

endpackage

// ----- hdl/spq_cell.sv -----
// one storage cell of the sorted shift chain
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  key_t       prev_key,
    input  logic       prev_gt,
    input  key_t       next_key,
    output key_t       key,
    output logic       gt
);

    key_t key_reg;
    key_t key_next;

    // cell is past the insert point when empty or holding a larger key
    assign gt  = !occupied || (key_reg > ctrl.key);
    assign key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.push && gt)
        begin
            key_next = prev_gt ? prev_key : ctrl.key;
        end
        else if (ctrl.pop)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ----- hdl/sorted_min_priority_queue_core.sv -----
// top level of the sorted min priority queue: cell chain, count and result registers
// result: the result item appears with done in the cycle after start is taken
// throughput: one item per cycle, busy stays low; every cell compares and shifts in parallel
// reset: rst_n clears the entry count, the status and the done strobe; stored keys need no clearing
// the receiver cannot stall: each result is shown for exactly one cycle
module sorted_min_priority_queue_core
    import spq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         func,
    input  logic signed [PORT_KEY_W-1:0] key_in,
    output logic                         busy,
    output logic                         done,
    output logic signed [PORT_KEY_W-1:0] front_key,
    output logic                         empty_res,
    output logic                         full_res,
    output logic [PORT_CNT_W-1:0]        entry_count,
    output logic [1:0]                   status
);

    count_t     count_reg;
    count_t     count_next;
    logic       done_reg;
    status_t    status_reg;
    status_t    status_next;
    logic       accept;
    logic       is_full;
    logic       queue_empty;
    cell_ctrl_t ctrl;
    logic signed [63:0] key_wide;
    logic signed [63:0] front_wide;

    key_t cell_key [CAPACITY];
    logic cell_gt  [CAPACITY];

    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign is_full     = (count_reg == count_t'(CAPACITY));
    assign queue_empty = (count_reg == '0);
    assign key_wide    = 64'(key_in);

    always_comb
    begin
        ctrl.key  = key_wide[KEY_WIDTH-1:0];
        ctrl.push = accept && (func_t'(func) == FUNC_PUSH) && !is_full;
        ctrl.pop  = accept && (func_t'(func) == FUNC_POP) && !queue_empty;
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - count_t'(1);
        end
        if (accept)
        begin
            case (func_t'(func))
                FUNC_PUSH: status_next = is_full ? STATUS_FULL : STATUS_OK;
                FUNC_POP:  status_next = queue_empty ? STATUS_EMPTY : STATUS_OK;
                default:   status_next = STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .occupied (count_reg > count_t'(i)),
            .prev_key ((i == 0) ? ctrl.key : cell_key[(i == 0) ? 0 : i - 1]),
            .prev_gt  ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .next_key (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
            .key      (cell_key[i]),
            .gt       (cell_gt[i])
        );
    end

    assign front_wide  = 64'(cell_key[0]);
    assign front_key   = queue_empty ? '0 : front_wide[PORT_KEY_W-1:0];
    assign done        = done_reg;
    assign empty_res   = queue_empty;
    assign full_res    = is_full;
    assign entry_count = PORT_CNT_W'(count_reg);
    assign status      = status_reg;

endmodule

// ----- hdl/spq_checker.sv -----
// port-level checks of the sorted min priority queue, bound to the top level
module spq_checker
    import spq_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [PORT_KEY_W-1:0] front_key,
    input logic                         empty_res,
    input logic                         full_res,
    input logic [PORT_CNT_W-1:0]        entry_count,
    input logic [1:0]                   status
);

    // each taken item yields exactly one result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("missing result item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result item without a taken item");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty_res) |-> (entry_count == '0 && front_key == '0))
        else $error("empty queue shows a key or count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FULL) |-> (full_res && $stable(entry_count)))
        else $error("rejected push changed the queue");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_EMPTY) |-> (empty_res && !full_res))
        else $error("rejected pop on a non-empty queue");

endmodule

bind sorted_min_priority_queue_core spq_checker u_spq_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench of sorted_min_priority_queue_core with a sorted key scoreboard and random push/pop items

module tb;
    import spq_pkg::*;

    localparam int   CYCLE_LIMIT = 100000;
    localparam int   RANDOM_ITEMS = 550;
    localparam key_t KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
    localparam key_t KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [PORT_KEY_W-1:0] front;
        logic                         empty_flag;
        logic                         full_flag;
        logic [PORT_CNT_W-1:0]        count;
        status_t                      code;
    } queue_result_t;

    class spq_scoreboard;
        key_t          sorted_keys[$];
        queue_result_t expected[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(func_t op, key_t k);
            queue_result_t r;
            int pos;
            r.code = STATUS_OK;
            if (op == FUNC_PUSH) begin
                if (sorted_keys.size() >= CAPACITY)
                    r.code = STATUS_FULL;
                else begin
                    // equal keys leave in arrival order
                    pos = 0;
                    while (pos < sorted_keys.size() && sorted_keys[pos] <= k)
                        pos++;
                    sorted_keys.insert(pos, k);
                end
            end
            else begin
                if (sorted_keys.size() == 0)
                    r.code = STATUS_EMPTY;
                else
                    void'(sorted_keys.pop_front());
            end
            r.front      = (sorted_keys.size() > 0) ? sorted_keys[0] : key_t'(0);
            r.empty_flag = (sorted_keys.size() == 0);
            r.full_flag  = (sorted_keys.size() >= CAPACITY);
            r.count      = PORT_CNT_W'(sorted_keys.size());
            expected.push_back(r);
        endfunction

        function void check_result(queue_result_t got, int cycle);
            queue_result_t want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("cycle %0d: result item with none expected", cycle);
                return;
            end
            want = expected.pop_front();
            if (got.front !== want.front || got.empty_flag !== want.empty_flag ||
                got.full_flag !== want.full_flag || got.count !== want.count ||
                got.code !== want.code) begin
                errors++;
                if (errors <= 10)
                    $display({"cycle %0d: expected key %0d empty %0b full %0b count %0d ",
                              "status %0d, got key %0d empty %0b full %0b count %0d status %0d"},
                             cycle, want.front, want.empty_flag, want.full_flag, want.count,
                             want.code, got.front, got.empty_flag, got.full_flag, got.count,
                             got.code);
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         func = FUNC_PUSH;
    logic signed [PORT_KEY_W-1:0] key_in = '0;
    logic                         busy;
    logic                         done;
    logic signed [PORT_KEY_W-1:0] front_key;
    logic                         empty_res;
    logic                         full_res;
    logic [PORT_CNT_W-1:0]        entry_count;
    logic [1:0]                   status;

    spq_scoreboard sb = new();
    int            cycle_count = 0;

    sorted_min_priority_queue_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .key_in      (key_in),
        .busy        (busy),
        .done        (done),
        .front_key   (front_key),
        .empty_res   (empty_res),
        .full_res    (full_res),
        .entry_count (entry_count),
        .status      (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** sorted_min_priority_queue_core: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        queue_result_t got;
        got = '{front_key, empty_res, full_res, entry_count, status_t'(status)};
        if (rst_n && done)
            sb.check_result(got, cycle_count);
    end

    function automatic key_t pick_key();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            1, 2:    return key_t'(int'($urandom_range(0, 8)) - 4);
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic send_item(func_t op, key_t k, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start  <= 1'b1;
        func   <= op;
        key_in <= k;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_item(op, k);
    endtask

    initial
    begin
        int    sent;
        int    seg_len;
        int    push_pct;
        bit    idle_on;
        func_t op;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: pop while empty, extreme and equal keys, fill, push while full
        send_item(FUNC_POP, KEY_MAX, 2);
        send_item(FUNC_PUSH, key_t'(0), 0);
        send_item(FUNC_PUSH, KEY_MAX, 1);
        send_item(FUNC_PUSH, KEY_MIN, 0);
        send_item(FUNC_PUSH, key_t'(-1), 3);
        send_item(FUNC_PUSH, key_t'(0), 0);
        send_item(FUNC_PUSH, KEY_MAX, 0);
        send_item(FUNC_PUSH, key_t'(1), 2);
        repeat (9) send_item(FUNC_PUSH, pick_key(), $urandom_range(0, 2));
        send_item(FUNC_PUSH, KEY_MIN, 0);
        repeat (5) send_item(FUNC_POP, pick_key(), $urandom_range(0, 2));

        // random: segments leaning toward push or pop so both full and empty recur
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(10, 40);
            case ($urandom_range(0, 3))
                0:       push_pct = 10;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = 97;
            endcase
            idle_on = ($urandom_range(0, 2) != 0);
            repeat (seg_len)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
                send_item(op, pick_key(), idle_on ? $urandom_range(0, 19) : 0);
                sent++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("** sorted_min_priority_queue_core: PASSED **");
        else
            $display("** sorted_min_priority_queue_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_min_priority_queue_core.sv
hdl/spq_checker.sv
verif/tb.sv
